// ----- sv/spq_pkg.sv -----
// Shared constants and types of the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int POS_W    = 4;
    localparam int LEN_W    = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    typedef logic signed [VAL_W-1:0] t_value;

    // Broadcast from the controller to every cell during the execute cycle.
    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        t_value value;
    } t_cell_ctrl;

endpackage

// ----- sv/spq_cell.sv -----
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occ,
    input  logic                i_prev_ge,
    input  spq_pkg::t_value     i_left_value,
    input  spq_pkg::t_value     i_right_value,
    output spq_pkg::t_value     o_value,
    output spq_pkg::t_value     o_next_value,
    output logic                o_ge,
    output logic                o_le,
    output logic                o_eq
);
    import spq_pkg::*;

    t_value r_value;
    t_value n_value;

    // An empty cell counts as "not greater" so a new value lands there.
    assign o_ge = !i_occ || (i_ctrl.value >= r_value);
    assign o_le = i_occ && (r_value <= i_ctrl.value);
    assign o_eq = i_occ && (r_value == i_ctrl.value);

    always_comb begin
        n_value = r_value;
        priority if (i_ctrl.ins_en) begin
            if (o_ge && !i_prev_ge) begin
                n_value = i_ctrl.value;
            end else if (o_ge) begin
                n_value = i_left_value;
            end
        end else if (i_ctrl.rem_en) begin
            // Entries from the first match onward pull in their right neighbor.
            if (o_le) begin
                n_value = i_right_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_next_value = n_value;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: request register, cell chain and result register.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-----------------------------------------------
//   request   | start / busy       | i_opcode, i_value
//   result    | o_valid (strobe)   | o_ok, o_position, o_length, o_head_valid,
//             |                    | o_head_value
//
// A request is taken when start is high and busy is low; busy then stays high for one
// execute cycle in which every cell compares its entry with the value and the chain
// shifts. The result strobe follows in the next cycle, and a new request may be issued
// in the cycle the result appears. Reset empties the queue at once; the result side
// cannot stall, so results are never held back.
module sorted_priority_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [spq_pkg::OP_W-1:0]   i_opcode,
    input  spq_pkg::t_value            i_value,
    output logic                       o_valid,
    output logic                       o_ok,
    output logic [spq_pkg::POS_W-1:0]  o_position,
    output logic [spq_pkg::LEN_W-1:0]  o_length,
    output logic                       o_head_valid,
    output spq_pkg::t_value            o_head_value
);
    import spq_pkg::*;

    logic             r_busy;
    logic [OP_W-1:0]  r_op;
    t_value           r_req_value;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    t_cell_ctrl          ctrl;
    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] ge;
    logic [CAPACITY-1:0] le;
    logic [CAPACITY-1:0] eq;
    t_value              cell_val  [CAPACITY];
    t_value              cell_next [CAPACITY];

    logic             full;
    logic             found;
    logic [IDX_W-1:0] ins_pos;
    logic [IDX_W-1:0] match_pos;
    logic             n_ok;
    logic [IDX_W-1:0] n_pos;

    function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] bits);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (bits[k]) begin
                idx = IDX_W'(k);
            end
        end
        return idx;
    endfunction

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign found = |eq;

    assign ctrl.ins_en = r_busy && (r_op == OP_INSERT) && !full;
    assign ctrl.rem_en = r_busy && (r_op == OP_REMOVE) && found;
    assign ctrl.value  = r_req_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_value left_v;
        t_value right_v;
        logic   prev_ge;

        assign occ[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_first
            assign left_v  = r_req_value;
            assign prev_ge = 1'b0;
        end else begin : g_mid
            assign left_v  = cell_val[g-1];
            assign prev_ge = ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_v = '0;
        end else begin : g_inner
            assign right_v = cell_val[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occ         (occ[g]),
            .i_prev_ge     (prev_ge),
            .i_left_value  (left_v),
            .i_right_value (right_v),
            .o_value       (cell_val[g]),
            .o_next_value  (cell_next[g]),
            .o_ge          (ge[g]),
            .o_le          (le[g]),
            .o_eq          (eq[g])
        );
    end

    // The list is descending, so the first "not greater" cell is the insert point and
    // the first occupied "not greater" cell is the match whenever any cell matches.
    assign ins_pos   = first_set(ge);
    assign match_pos = first_set(le);

    always_comb begin
        n_count = r_count;
        n_ok    = 1'b0;
        n_pos   = '0;
        unique case (r_op)
            OP_INSERT: begin
                if (!full) begin
                    n_ok    = 1'b1;
                    n_pos   = ins_pos;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (found) begin
                    n_ok    = 1'b1;
                    n_pos   = match_pos;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_FIND: begin
                if (found) begin
                    n_ok  = 1'b1;
                    n_pos = match_pos;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_busy  <= start && !r_busy;
            o_valid <= r_busy;
            if (r_busy) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_op        <= i_opcode;
            r_req_value <= i_value;
        end
        if (r_busy) begin
            o_ok         <= n_ok;
            o_position   <= POS_W'(n_pos);
            o_length     <= LEN_W'(n_count);
            o_head_valid <= (n_count != '0);
            o_head_value <= (n_count != '0) ? cell_next[0] : '0;
        end
    end

    assign busy = r_busy;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (cell_val[0] >= cell_val[1]))
        else $error("head entries out of order");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> o_valid)
        else $error("execute cycle produced no result");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_busy))
        else $error("result without a request");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> $stable(r_count))
        else $error("entry count changed while idle");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench of the sorted priority queue: directed table, then random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 1026;

    typedef struct packed {
        logic              ok;
        logic [POS_W-1:0]  position;
        logic [LEN_W-1:0]  length;
        logic              head_valid;
        t_value            head_value;
    } t_pq_result;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        t_value          value;
        logic            typed;
        t_pq_result      result;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_opcode;
    t_value            i_value;
    logic              o_valid;
    logic              o_ok;
    logic [POS_W-1:0]  o_position;
    logic [LEN_W-1:0]  o_length;
    logic              o_head_valid;
    t_value            o_head_value;

    // Mirror of the queue contents, kept in descending order.
    t_value     sorted_model[CAPACITY];
    int         model_count;
    t_pq_result pending_results[$];
    int         mismatch_count;

    // Rows with typed set carry a written-out expectation that replaces the mirror's prediction.
    t_stim_row directed_rows[DIRECTED_ROWS] = '{
        '{OP_FIND,   32'h0000_0000, 1'b1, '{1'b0, 4'd0, 5'd0, 1'b0, 32'h0}},
        '{OP_REMOVE, 32'h0000_0005, 1'b1, '{1'b0, 4'd0, 5'd0, 1'b0, 32'h0}},
        '{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd0, 5'd0, 1'b0, 32'h0}},
        '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd0, 5'd1, 1'b1, 32'h7FFF_FFFF}},
        '{OP_INSERT, 32'h8000_0000, 1'b1, '{1'b1, 4'd1, 5'd2, 1'b1, 32'h7FFF_FFFF}},
        '{OP_INSERT, 32'h0000_0000, 1'b1, '{1'b1, 4'd1, 5'd3, 1'b1, 32'h7FFF_FFFF}},
        '{OP_INSERT, 32'h0000_0000, 1'b0, '0},
        '{OP_FIND,   32'h8000_0000, 1'b0, '0},
        '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
        '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_INSERT, 32'h0000_0001, 1'b0, '0},
        '{OP_INSERT, 32'h1234_5678, 1'b0, '0},
        '{OP_INSERT, 32'hEDCB_A987, 1'b0, '0},
        '{OP_INSERT, 32'h0000_0002, 1'b0, '0},
        '{OP_INSERT, 32'hFFFF_FFFE, 1'b0, '0},
        '{OP_INSERT, 32'h5555_5555, 1'b0, '0},
        '{OP_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
        '{OP_INSERT, 32'h0000_03E8, 1'b0, '0},
        '{OP_INSERT, 32'hFFFF_FC18, 1'b0, '0},
        '{OP_INSERT, 32'h4000_0000, 1'b0, '0},
        '{OP_INSERT, 32'hC000_0000, 1'b0, '0},
        '{OP_INSERT, 32'h0000_0005, 1'b1, '{1'b0, 4'd0, 5'd16, 1'b1, 32'h7FFF_FFFF}},
        '{OP_FIND,   32'h8000_0000, 1'b0, '0},
        '{OP_REMOVE, 32'h7FFF_FFFF, 1'b0, '0}
    };

    sorted_priority_queue u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_ok         (o_ok),
        .o_position   (o_position),
        .o_length     (o_length),
        .o_head_valid (o_head_valid),
        .o_head_value (o_head_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(2_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    // Applies one request to the mirror and returns the result the queue should report.
    function automatic t_pq_result apply_request(logic [OP_W-1:0] op, t_value v);
        t_pq_result r;
        int         hit;
        int         slot;
        r = '0;
        hit = 0;
        while (hit < model_count && sorted_model[hit] != v) hit++;
        case (op)
            OP_INSERT: begin
                if (model_count < CAPACITY) begin
                    slot = 0;
                    while (slot < model_count && v < sorted_model[slot]) slot++;
                    for (int k = model_count; k > slot; k--) sorted_model[k] = sorted_model[k-1];
                    sorted_model[slot] = v;
                    model_count++;
                    r.ok = 1'b1;
                    r.position = slot[POS_W-1:0];
                end
            end
            OP_REMOVE: begin
                if (hit < model_count) begin
                    for (int k = hit; k < model_count - 1; k++) sorted_model[k] = sorted_model[k+1];
                    model_count--;
                    r.ok = 1'b1;
                    r.position = hit[POS_W-1:0];
                end
            end
            OP_FIND: begin
                if (hit < model_count) begin
                    r.ok = 1'b1;
                    r.position = hit[POS_W-1:0];
                end
            end
            default: ;
        endcase
        r.length     = model_count[LEN_W-1:0];
        r.head_valid = (model_count > 0);
        r.head_value = (model_count > 0) ? sorted_model[0] : '0;
        return r;
    endfunction

    task automatic issue(logic [OP_W-1:0] op, t_value v, logic typed, t_pq_result typed_result);
        t_pq_result predicted;
        start    <= 1'b1;
        i_opcode <= op;
        i_value  <= v;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = apply_request(op, v);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic maybe_idle(int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_pq_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no request outstanding");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, o_ok);
                    mismatch_count++;
                end
                if (o_position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_position);
                    mismatch_count++;
                end
                if (o_length !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length, o_length);
                    mismatch_count++;
                end
                if (o_head_valid !== want.head_valid) begin
                    $error("head_valid: expected %0d, got %0d", want.head_valid, o_head_valid);
                    mismatch_count++;
                end
                if (o_head_value !== want.head_value) begin
                    $error("head_value: expected %0d, got %0d", want.head_value, o_head_value);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int              idle_pct[3];
        bit              filling;
        int              roll;
        logic [OP_W-1:0] op;
        t_value          v;

        idle_pct = '{16, 65, 0};
        filling = 1'b1;
        model_count = 0;
        mismatch_count = 0;
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_opcode <= OP_INSERT;
        i_value  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            maybe_idle(idle_pct[0]);
            issue(directed_rows[r].opcode, directed_rows[r].value,
                  directed_rows[r].typed, directed_rows[r].result);
        end
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
                // Alternate long fill and drain stretches so the full and empty ends get hit.
                if (model_count == 0) filling = 1'b1;
                else if (model_count == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
                else if ($urandom_range(29) == 0) filling = ~filling;

                roll = $urandom_range(99);
                if (roll < 2)       op = OP_UNUSED;
                else if (roll < 20) op = OP_FIND;
                else if (roll < 80) op = filling ? OP_INSERT : OP_REMOVE;
                else                op = filling ? OP_REMOVE : OP_INSERT;

                roll = $urandom_range(99);
                if (roll < 40 && model_count > 0) begin
                    v = sorted_model[$urandom_range(model_count - 1)];
                end else if (roll < 75) begin
                    v = t_value'(int'($urandom_range(6)) - 3);
                end else if (roll < 85) begin
                    case ($urandom_range(3))
                        0:       v = 32'h7FFF_FFFF;
                        1:       v = 32'h8000_0000;
                        2:       v = 32'h0000_0000;
                        default: v = 32'hFFFF_FFFF;
                    endcase
                end else begin
                    v = $urandom;
                end

                maybe_idle(idle_pct[phase]);
                issue(op, v, 1'b0, '0);
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
test/testbench.sv
